// File: rtl/hcbp_pkg.sv
// Package for the hop code bit packer: word and field widths, saturation
// limits, register indexes and the result record used by the output queue.
// No dependencies.
`default_nettype none

package hcbp_pkg;

	localparam int WORD_BITS       = 32;
	localparam int BYTE_BITS       = 8;
	localparam int TABLE_ENTRIES   = 9;
	localparam int LOW_ENTRIES     = 5;
	localparam int CFG_DATA_BITS   = 40;
	localparam int WORDS_BITS      = 22;
	localparam int FRAME_BYTE_BITS = 24;

	localparam logic [WORDS_BITS-1:0]      WORDS_MAX       = '1;
	localparam logic [FRAME_BYTE_BITS-1:0] FRAME_BYTES_MAX = '1;

	typedef enum logic [1:0] {
		REG_CODE_TABLE_LOW  = 2'd0,
		REG_CODE_TABLE_HIGH = 2'd1,
		REG_CODE_LENGTHS    = 2'd2,
		REG_RAW_CHANNELS    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]       word;
		logic [2:0]                 count;
		logic                       done;
		logic [FRAME_BYTE_BITS-1:0] bytes;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/hop_code_bit_packer_unit.sv
// Top level of the hop code bit packer: input register, packing logic,
// configuration registers and a two-entry result queue.
// Depends on hcbp_pkg.
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_ready   symbol_or_byte, end_of_frame
// out      source     out_valid / out_ready packed_word, byte_count, frame_done, frame_bytes
// cfg      sink       cfg_we                cfg_index, cfg_data
//
// One item is taken per cycle while the result queue has room; after an item that
// yields two words, the input waits as the queue drains one word a cycle while out_ready is high.
// An item waits in the input register until the result queue has room for its results.
// Reset clears the packing state and the queue; no clearing pass is needed.
// A stalled output fills the two-entry queue and then stops the input.
`default_nettype none

module hop_code_bit_packer_unit #(
	parameter int MAX_CODE_BITS = 8,
	parameter int NUM_SYMBOLS   = 9
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          symbol_or_byte,
	input  wire logic                                end_of_frame,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [hcbp_pkg::WORD_BITS-1:0]           packed_word,
	output logic [2:0]                               byte_count,
	output logic                                     frame_done,
	output logic [hcbp_pkg::FRAME_BYTE_BITS-1:0]     frame_bytes,
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [hcbp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import hcbp_pkg::*;

	localparam logic [7:0] SYM_MAX = 8'(NUM_SYMBOLS - 1);
	localparam logic [3:0] LEN_MAX = 4'(MAX_CODE_BITS);

	logic [39:0] code_low_q;
	logic [31:0] code_high_q;
	logic [35:0] code_len_q;
	logic [1:0]  raw_ch_q;

	logic       valid_s1;
	logic [7:0] item_s1;
	logic       last_s1;

	logic [WORD_BITS-1:0]  acc_q;
	logic [4:0]            pos_q;
	logic [1:0]            raw_seen_q;
	logic [WORDS_BITS-1:0] words_q;

	result_t    slot_q [2];
	logic       rd_q;
	logic [1:0] count_q;

	logic [7:0]            codes [TABLE_ENTRIES];
	logic [3:0]            lens  [TABLE_ENTRIES];
	logic                  is_raw;
	logic [3:0]            sym;
	logic [3:0]            len_raw;
	logic [3:0]            len;
	logic [8:0]            mask;
	logic [7:0]            code;
	logic [39:0]           acc_wide;
	logic [5:0]            pos_sum;
	logic                  full;
	logic [4:0]            pos_new;
	logic [WORD_BITS-1:0]  acc_new;
	logic [WORDS_BITS-1:0] words_new;
	logic                  flush;
	logic [2:0]            flush_count;
	logic [1:0]            n_res;
	logic                  adv;
	logic                  pop;
	logic                  wr0;
	result_t               res_full;
	result_t               res_flush;
	result_t               res_first;

	function automatic logic [FRAME_BYTE_BITS-1:0] frame_size(
		input logic [WORDS_BITS-1:0] words,
		input logic [2:0]            extra
	);
		logic [FRAME_BYTE_BITS:0] total;
		total = {1'b0, words, 2'b00} + (FRAME_BYTE_BITS + 1)'(extra);
		if (total[FRAME_BYTE_BITS]) begin
			return FRAME_BYTES_MAX;
		end
		return total[FRAME_BYTE_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_low_q  <= '0;
			code_high_q <= '0;
			code_len_q  <= '0;
			raw_ch_q    <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CODE_TABLE_LOW:  code_low_q  <= cfg_data;
				REG_CODE_TABLE_HIGH: code_high_q <= cfg_data[31:0];
				REG_CODE_LENGTHS:    code_len_q  <= cfg_data[35:0];
				REG_RAW_CHANNELS:    raw_ch_q    <= cfg_data[1:0];
				default:             raw_ch_q    <= raw_ch_q;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (i < LOW_ENTRIES) begin
				codes[i] = code_low_q[8*i +: 8];
			end else begin
				codes[i] = code_high_q[8*(i-LOW_ENTRIES) +: 8];
			end
			lens[i] = code_len_q[4*i +: 4];
		end
	end

	always_comb begin
		is_raw  = raw_seen_q < raw_ch_q;
		sym     = (item_s1 > SYM_MAX) ? SYM_MAX[3:0] : item_s1[3:0];
		len_raw = (lens[sym] > LEN_MAX) ? LEN_MAX : lens[sym];
		len     = is_raw ? 4'(BYTE_BITS) : len_raw;
		mask    = (9'd1 << len_raw) - 9'd1;
		code    = is_raw ? item_s1 : (codes[sym] & mask[7:0]);

		acc_wide = {8'b0, acc_q} | ({32'b0, code} << pos_q);
		pos_sum  = {1'b0, pos_q} + {2'b0, len};
		full     = pos_sum[5];
		pos_new  = pos_sum[4:0];
		acc_new  = full ? {24'b0, acc_wide[39:32]} : acc_wide[31:0];

		words_new = (full && words_q != WORDS_MAX) ? words_q + 1'b1 : words_q;

		res_full.word  = acc_wide[31:0];
		res_full.count = 3'd4;
		res_full.done  = last_s1 && pos_new == '0;
		res_full.bytes = res_full.done ? frame_size(words_new, 3'd0) : '0;

		flush_count     = 3'((6'(pos_new) + 6'd7) >> 3);
		res_flush.word  = (pos_new != '0) ? acc_new : '0;
		res_flush.count = flush_count;
		res_flush.done  = 1'b1;
		res_flush.bytes = frame_size(words_new, flush_count);

		flush     = last_s1 && (pos_new != '0 || !full);
		n_res     = {1'b0, full} + {1'b0, flush};
		res_first = full ? res_full : res_flush;
	end

	assign adv      = valid_s1 && (n_res <= 2'd2 - count_q);
	assign in_ready = !valid_s1 || adv;
	assign pop      = out_valid && out_ready;
	assign wr0      = rd_q ^ count_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= symbol_or_byte;
			last_s1 <= end_of_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pos_q      <= '0;
			raw_seen_q <= '0;
			words_q    <= '0;
		end else if (adv) begin
			if (last_s1) begin
				acc_q      <= '0;
				pos_q      <= '0;
				raw_seen_q <= '0;
				words_q    <= '0;
			end else begin
				acc_q   <= acc_new;
				pos_q   <= pos_new;
				words_q <= words_new;
				if (is_raw) begin
					raw_seen_q <= raw_seen_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + (adv ? n_res : 2'd0) - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_res != '0) begin
			slot_q[wr0] <= res_first;
		end
		if (adv && n_res == 2'd2) begin
			slot_q[~wr0] <= res_flush;
		end
	end

	assign out_valid   = count_q != '0;
	assign packed_word = slot_q[rd_q].word;
	assign byte_count  = slot_q[rd_q].count;
	assign frame_done  = slot_q[rd_q].done;
	assign frame_bytes = slot_q[rd_q].bytes;

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue holds more than two entries");

	a_pair_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		adv && n_res == 2'd2 |-> last_s1 && full && !res_full.done)
		else $error("two results from an item that does not end a frame");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> pos_q == '0 && words_q == '0 && raw_seen_q == '0)
		else $error("packing state not cleared after the last item");

	a_last_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |-> n_res != '0)
		else $error("last item of a frame produced no result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count <= 3'd4)
		else $error("byte count above four");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for hop_code_bit_packer_unit: directed frames, then random frames
// under several register settings, with random gaps on the input and output channels.
// Depends on hcbp_pkg and the packer RTL; an internal bit-accurate predictor checks every word.
`default_nettype none

module tb_top;
	import hcbp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SYMBOLS   = 9;
	localparam int MAX_CODE_BITS = 8;
	localparam int DRAIN_CYCLES  = 10;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 450;
	localparam int PHASES        = 8;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [7:0]                 symbol_or_byte = 8'd0;
	logic                       end_of_frame = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [WORD_BITS-1:0]       packed_word;
	logic [2:0]                 byte_count;
	logic                       frame_done;
	logic [FRAME_BYTE_BITS-1:0] frame_bytes;
	logic                       cfg_we = 1'b0;
	logic [1:0]                 cfg_index = REG_CODE_TABLE_LOW;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

	// Register copies and packing state of the predictor.
	logic [39:0]           code_lo;
	logic [31:0]           code_hi;
	logic [35:0]           code_len;
	logic [1:0]            raw_count;
	logic [31:0]           acc_bits;
	logic [4:0]            acc_fill;
	logic [1:0]            raw_taken;
	logic [WORDS_BITS-1:0] full_words;

	result_t     words_due[$];
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned cycle_count;
	int unsigned stall_left;
	bit          idling;

	hop_code_bit_packer_unit #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.NUM_SYMBOLS  (NUM_SYMBOLS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.symbol_or_byte(symbol_or_byte),
		.end_of_frame  (end_of_frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_word   (packed_word),
		.byte_count    (byte_count),
		.frame_done    (frame_done),
		.frame_bytes   (frame_bytes),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idling || r < 60)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void queue_word(input logic [31:0] word, input logic [2:0] count,
			input logic done, input logic [23:0] bytes);
		result_t r;
		r.word  = word;
		r.count = count;
		r.done  = done;
		r.bytes = bytes;
		words_due.push_back(r);
	endfunction

	function automatic logic [23:0] frame_size(input logic [2:0] extra);
		logic [31:0] total;
		total = {8'd0, full_words, 2'b00} + 32'(extra);
		return (total > 32'(FRAME_BYTES_MAX)) ? FRAME_BYTES_MAX : total[23:0];
	endfunction

	function automatic void pack_item(input logic [7:0] item, input logic last);
		logic [7:0]  code;
		logic [3:0]  len;
		logic [3:0]  sym;
		logic [8:0]  mask;
		logic [63:0] wide;
		logic [6:0]  fill;
		logic        full;
		logic [2:0]  count;
		full = 1'b0;
		if (raw_taken < raw_count) begin
			code = item;
			len = 4'd8;
			raw_taken = raw_taken + 2'd1;
		end else begin
			if (item > 8'(NUM_SYMBOLS - 1))
				sym = 4'(NUM_SYMBOLS - 1);
			else
				sym = item[3:0];
			if (sym < 4'(LOW_ENTRIES))
				code = code_lo[8*sym +: 8];
			else
				code = code_hi[8*(sym-LOW_ENTRIES) +: 8];
			len = code_len[4*sym +: 4];
			if (len > 4'(MAX_CODE_BITS))
				len = 4'(MAX_CODE_BITS);
			mask = (9'd1 << len) - 9'd1;
			code = code & mask[7:0];
		end
		wide = {32'd0, acc_bits} | ({56'd0, code} << acc_fill);
		fill = acc_fill + len;
		if (fill >= 7'd32) begin
			if (full_words != WORDS_MAX)
				full_words = full_words + 1'b1;
			fill = fill - 7'd32;
			full = 1'b1;
			if (last && fill == 7'd0)
				queue_word(wide[31:0], 3'd4, 1'b1, frame_size(3'd0));
			else
				queue_word(wide[31:0], 3'd4, 1'b0, 24'd0);
			wide = wide >> 32;
		end
		acc_bits = wide[31:0];
		acc_fill = fill[4:0];
		if (last) begin
			if (acc_fill != 5'd0) begin
				count = 3'((6'(acc_fill) + 6'd7) >> 3);
				queue_word(acc_bits, count, 1'b1, frame_size(count));
			end else if (!full) begin
				queue_word(32'd0, 3'd0, 1'b1, frame_size(3'd0));
			end
			acc_bits = '0;
			acc_fill = '0;
			raw_taken = '0;
			full_words = '0;
		end
	endfunction

	task automatic send_item(input logic [7:0] item, input logic last);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		symbol_or_byte <= item;
		end_of_frame <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		pack_item(item, last);
		items_sent++;
	endtask

	// Holds the input idle until every predicted word has been transferred and the
	// block has had time to finish items that produce nothing.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [39:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_CODE_TABLE_LOW:  code_lo = value;
			REG_CODE_TABLE_HIGH: code_hi = value[31:0];
			REG_CODE_LENGTHS:    code_len = value[35:0];
			REG_RAW_CHANNELS:    raw_count = value[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_setup(input logic [39:0] lo, input logic [31:0] hi,
			input logic [35:0] lens, input logic [1:0] raws);
		wait_drained();
		write_reg(REG_CODE_TABLE_LOW, lo);
		write_reg(REG_CODE_TABLE_HIGH, {8'd0, hi});
		write_reg(REG_CODE_LENGTHS, {4'd0, lens});
		write_reg(REG_RAW_CHANNELS, {38'd0, raws});
	endtask

	task automatic send_frame(input int unsigned n_items);
		logic [7:0] item;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i < raw_count || $urandom_range(0, 99) >= 80)
				item = 8'($urandom_range(0, 255));
			else
				item = 8'($urandom_range(0, NUM_SYMBOLS - 1));
			send_item(item, i == n_items - 1);
		end
	endtask

	// With reset values every symbol has length zero, so only the raw bytes count.
	task automatic test_reset_values();
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h5A, 1'b0);
		send_item(8'd4, 1'b1);
	endtask

	// One raw byte and every symbol at full length, including clamped values, ending
	// exactly on a word boundary.
	task automatic test_every_symbol();
		load_setup(40'hA1_B2_C3_D4_E5, 32'h96_87_78_69, 36'h8_8888_8888, 2'd1);
		send_item(8'h80, 1'b0);
		for (int s = 0; s < NUM_SYMBOLS; s++)
			send_item(8'(s), 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'd9, 1'b1);
	endtask

	// Oversized length nibbles, codes wider than their length, no raw bytes, and a
	// final item that both completes a word and leaves bits to flush.
	task automatic test_lengths_and_masking();
		load_setup(40'hFF_FF_FF_FF_FF, 32'hFFFF_FFFF, 36'h0_0000_139F, 2'd0);
		send_item(8'd2, 1'b0);
		send_item(8'd0, 1'b0);
		send_item(8'd0, 1'b0);
		send_item(8'd0, 1'b0);
		send_item(8'd1, 1'b1);
	endtask

	task automatic test_empty_frame();
		load_setup(40'hFF_FF_FF_FF_FF, 32'hFFFF_FFFF, 36'h0, 2'd0);
		send_item(8'd3, 1'b1);
	endtask

	task automatic test_random_frames();
		logic [63:0]  r64;
		logic [35:0]  lens;
		logic [1:0]   raws;
		int unsigned  phase_end;
		int unsigned  r;
		int unsigned  frame_len;
		for (int p = 0; p < PHASES; p++) begin
			r64 = {$urandom, $urandom};
			lens = r64[35:0];
			raws = 2'($urandom_range(0, 3));
			case (p)
				0: begin
					lens = 36'h8_8888_8888;
					raws = 2'd3;
				end
				1: begin
					lens = 36'hF_FFFF_FFFF;
					raws = 2'd0;
				end
				2: lens = 36'h0;
				3: r64 = '1;
				4: r64 = '0;
				default: ;
			endcase
			load_setup(r64[39:0], {$urandom}, lens, raws);
			idling = (p % 3) != 0;
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					frame_len = $urandom_range(1, 12);
				else if (r < 95)
					frame_len = $urandom_range(13, 40);
				else
					frame_len = $urandom_range(41, 150);
				if (frame_len > phase_end - items_sent)
					frame_len = phase_end - items_sent;
				send_frame(frame_len);
			end
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idling && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: word %h count %0d done %0d bytes %0d",
						packed_word, byte_count, frame_done, frame_bytes);
			end else begin
				want = words_due.pop_front();
				if (packed_word !== want.word || byte_count !== want.count ||
						frame_done !== want.done || frame_bytes !== want.bytes) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
							want.word, want.count, want.done, want.bytes,
							packed_word, byte_count, frame_done, frame_bytes);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		code_lo = '0;
		code_hi = '0;
		code_len = '0;
		raw_count = 2'd3;
		acc_bits = '0;
		acc_fill = '0;
		raw_taken = '0;
		full_words = '0;
		mismatches = 0;
		items_sent = 0;
		cycle_count = 0;
		stall_left = 0;
		idling = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_every_symbol();
		test_lengths_and_masking();
		test_empty_frame();
		test_random_frames();
		wait_drained();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
